[hdl/gtbank_pkg.sv]
// ----------------------------------------------------------------------------
// gtbank_pkg
// shared types, constants and saturation helpers for the gammatone biquad
// cascade filterbank
// ----------------------------------------------------------------------------
package gtbank_pkg;

    // item commands
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // configuration register indexes
    localparam logic REG_ACTIVE_CHANNELS = 1'b0;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int CH_W     = 6;
    localparam int SEL_W    = 4;
    localparam int ACT_W    = 7;
    localparam int OUT_W    = 24;

    // datapath widths
    localparam int SIG_W    = 40;
    localparam int HALF_W   = 20;
    localparam int MOP_W    = HALF_W + 1;
    localparam int PROD_W   = COEF_W + MOP_W;
    localparam int ACC_W    = 72;
    localparam int FRAC_W   = 28;
    localparam int MQ_W     = ACC_W - FRAC_W;
    localparam int SUM_W    = 48;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

    // coefficient selects of the shared feedback pair and of the first b0
    localparam int SEL_A1 = 0;
    localparam int SEL_A2 = 1;
    localparam int SEL_B0 = 2;

    typedef logic signed [SIG_W-1:0] sig_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    function automatic sig_t sat40(input sum_t v);
        sig_t r;
        if (v[SUM_W-1:SIG_W-1] == '0 || v[SUM_W-1:SIG_W-1] == '1)
        begin
            r = v[SIG_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(SIG_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SIG_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat24(input logic signed [31:0] v);
        logic signed [OUT_W-1:0] r;
        if (v[31:OUT_W-1] == '0 || v[31:OUT_W-1] == '1)
        begin
            r = v[OUT_W-1:0];
        end
        else if (v[31])
        begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[hdl/gammatone_biquad_cascade_bank.sv]
// ----------------------------------------------------------------------------
// gammatone_biquad_cascade_bank
// filterbank of four-biquad cascades sharing one multiplier under a sequencer
// ----------------------------------------------------------------------------
// A write word (command 1) stores one Q4.28 coefficient.
// A filter word (command 0) runs the Q1.15 sample through channels
// 0 .. N-1, N being active_channels held to 1 .. NUM_CHANNELS, and gives one
// saturated Q1.23 word per channel in channel order, the last one marked.
// The input is stalled while a sample is at work. Every coefficient product
// goes through one 32x21 multiplier as two partial products, five products
// per biquad. After reset the stage state memory is zeroed, one row a
// cycle, before the first word is taken; the configuration port works
// throughout.
// ----------------------------------------------------------------------------
module gammatone_biquad_cascade_bank
    import gtbank_pkg::*;
#(
    parameter int NUM_CHANNELS = 64,
    parameter int NUM_STAGES   = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [CH_W-1:0]            coeff_channel,
    input  logic [SEL_W-1:0]           coeff_select,
    input  logic signed [COEF_W-1:0]   coeff_value,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CH_W-1:0]            channel_out,
    output logic signed [OUT_W-1:0]    filtered_sample,
    output logic                       last_channel
);

    localparam int COEFS      = 2 + 3 * NUM_STAGES;
    localparam int COEF_DEPTH = NUM_CHANNELS * COEFS;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int SA_W       = $clog2(COEFS);
    localparam int ROWS       = NUM_CHANNELS * NUM_STAGES;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int STG_W      = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    localparam logic [ACT_W-1:0] NCH_MAX   = ACT_W'(NUM_CHANNELS);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [STG_W-1:0] STG_LAST  = STG_W'(NUM_STAGES - 1);
    localparam logic [CA_W-1:0]  CBASE_INC = CA_W'(COEFS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [3:0] STEP_READ_LAST = 4'd8;
    localparam logic [3:0] STEP_X_LAST    = 4'd6;
    localparam logic [3:0] STEP_Y         = 4'd4;
    localparam logic [3:0] STEP_T1        = 4'd6;
    localparam logic [3:0] STEP_T2        = 4'd8;
    localparam logic [3:0] STEP_S0        = 4'd10;
    localparam logic [3:0] STEP_LAST      = 4'd12;
    localparam logic [2:0] RD_FEEDBACK    = 3'd3;

    // control state
    logic [1:0]       state_reg, state_next;
    logic [3:0]       step_reg, step_next;
    logic [STG_W-1:0] stage_reg, stage_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CA_W-1:0]  cbase_reg, cbase_next;
    logic [ROW_W-1:0] clr_reg, clr_next;
    logic [ACT_W-1:0] active_reg, active_next;
    logic [ACT_W-1:0] n_act_reg, n_act_next;
    logic             out_valid_reg, out_valid_next;

    // datapath
    logic signed [SAMPLE_W-1:0] samp_reg, samp_next;
    sig_t                       x_reg, x_next;
    sig_t                       y_reg, y_next;
    logic signed [MQ_W:0]       t1_reg, t1_next;
    logic signed [MQ_W-1:0]     t2_reg, t2_next;
    sig_t                       s0n_reg, s0n_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [CH_W-1:0]            chan_out_reg, chan_out_next;
    logic signed [OUT_W-1:0]    filt_reg, filt_next;
    logic                       last_reg, last_next;

    // memories
    logic signed [COEF_W-1:0]  coef_mem [COEF_DEPTH];
    logic [2*SIG_W-1:0]        st_mem [ROWS];
    logic signed [COEF_W-1:0]  coef_rd_reg;
    logic [2*SIG_W-1:0]        st_rd_reg;

    logic                  cfg_wr;
    logic                  in_acc;
    logic                  coef_we;
    logic [CA_W-1:0]       coef_waddr;
    logic                  coef_re;
    logic [2:0]            rd_idx;
    logic [SA_W-1:0]       rd_sel;
    logic [CA_W-1:0]       coef_raddr;
    logic                  st_we;
    logic [ROW_W-1:0]      st_waddr;
    logic [2*SIG_W-1:0]    st_wdata;
    logic                  st_re;
    sig_t                  mop;
    logic signed [MOP_W-1:0] mul_b;
    logic signed [MQ_W-1:0]  mq;
    sig_t                  s0_old;
    sig_t                  s1_old;
    sig_t                  s1_new;
    logic signed [SIG_W:0] y_round;
    logic [ACT_W-1:0]      n_act_sat;
    logic                  is_last;
    logic                  out_free;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_ACTIVE_CHANNELS) ? {25'd0, active_reg} : 32'd0;

    assign in_stall        = (state_reg != ST_IDLE);
    assign in_acc          = in_valid && !in_stall;
    assign out_valid       = out_valid_reg;
    assign channel_out     = chan_out_reg;
    assign filtered_sample = filt_reg;
    assign last_channel    = last_reg;
    assign out_free        = !out_valid_reg || !out_stall;

    // coefficient write path
    assign coef_we    = in_acc && (command == CMD_WRITE)
                        && (32'(coeff_channel) < NUM_CHANNELS)
                        && (32'(coeff_select) < COEFS);
    assign coef_waddr = CA_W'(32'(coeff_channel) * COEFS + 32'(coeff_select));

    // coefficient read order per stage: b0, b1, b2, a1, a2
    assign rd_idx = step_reg[3:1];
    always_comb
    begin
        if (rd_idx < RD_FEEDBACK)
        begin
            rd_sel = SA_W'(SEL_B0 + 3 * 32'(stage_reg) + 32'(rd_idx));
        end
        else if (rd_idx == RD_FEEDBACK)
        begin
            rd_sel = SA_W'(SEL_A1);
        end
        else
        begin
            rd_sel = SA_W'(SEL_A2);
        end
    end
    assign coef_raddr = cbase_reg + CA_W'(rd_sel);
    assign coef_re    = (state_reg == ST_RUN) && !step_reg[0] && (step_reg <= STEP_READ_LAST);
    assign st_re      = (state_reg == ST_RUN) && (step_reg == 4'd0);

    // shared multiplier operand: low half unsigned, high half signed
    assign mop   = (step_reg <= STEP_X_LAST) ? x_reg : y_reg;
    assign mul_b = step_reg[0] ? $signed({1'b0, mop[HALF_W-1:0]})
                               : $signed({mop[SIG_W-1], mop[SIG_W-1:HALF_W]});

    assign mq     = $signed(acc_reg[ACC_W-1:FRAC_W]);
    assign s0_old = $signed(st_rd_reg[2*SIG_W-1:SIG_W]);
    assign s1_old = $signed(st_rd_reg[SIG_W-1:0]);
    assign s1_new = sat40(SUM_W'(t2_reg) - SUM_W'(mq));

    assign st_we    = (state_reg == ST_CLEAR)
                      || ((state_reg == ST_RUN) && (step_reg == STEP_LAST));
    assign st_waddr = (state_reg == ST_CLEAR) ? clr_reg : row_reg;
    assign st_wdata = (state_reg == ST_CLEAR) ? '0 : {s0n_reg, s1_new};

    assign y_round   = (SIG_W+1)'(y_reg) + (SIG_W+1)'(256);
    assign is_last   = ({1'b0, ch_reg} == n_act_reg - ACT_W'(1));
    assign n_act_sat = (active_reg == '0) ? ACT_W'(1)
                     : (active_reg > NCH_MAX) ? NCH_MAX : active_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        stage_next     = stage_reg;
        ch_next        = ch_reg;
        row_next       = row_reg;
        cbase_next     = cbase_reg;
        clr_next       = clr_reg;
        active_next    = active_reg;
        n_act_next     = n_act_reg;
        out_valid_next = out_valid_reg && out_stall;
        samp_next      = samp_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        s0n_next       = s0n_reg;
        acc_next       = acc_reg;
        chan_out_next  = chan_out_reg;
        filt_next      = filt_reg;
        last_next      = last_reg;

        if (cfg_wr && (paddr[2] == REG_ACTIVE_CHANNELS))
        begin
            active_next = pwdata[ACT_W-1:0];
        end

        // accumulate partial products of the shared multiplier
        if (step_reg >= 4'd2 && step_reg <= 4'd11)
        begin
            if (!step_reg[0])
            begin
                acc_next = ACC_W'(prod_reg) + (ACC_W'(1) <<< (FRAC_W - 1));
            end
            else
            begin
                acc_next = acc_reg + (ACC_W'(prod_reg) <<< HALF_W);
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ROW_W'(1);
                if (clr_reg == ROW_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc && (command == CMD_FILTER))
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                    stage_next = '0;
                    ch_next    = '0;
                    row_next   = '0;
                    cbase_next = '0;
                    n_act_next = n_act_sat;
                    samp_next  = sample_in;
                    x_next     = SIG_W'(sample_in) <<< 17;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    STEP_Y:
                    begin
                        y_next = sat40(SUM_W'(mq) + SUM_W'(s0_old));
                    end
                    STEP_T1:
                    begin
                        t1_next = (MQ_W+1)'(mq) + (MQ_W+1)'(s1_old);
                    end
                    STEP_T2:
                    begin
                        t2_next = mq;
                    end
                    STEP_S0:
                    begin
                        s0n_next = sat40(SUM_W'(t1_reg) - SUM_W'(mq));
                    end
                    STEP_LAST:
                    begin
                        step_next = '0;
                        row_next  = row_reg + ROW_W'(1);
                        x_next    = y_reg;
                        if (stage_reg == STG_LAST)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            stage_next = stage_reg + STG_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    chan_out_next  = ch_reg;
                    filt_next      = sat24(32'(y_round >>> 9));
                    last_next      = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        step_next  = '0;
                        stage_next = '0;
                        ch_next    = ch_reg + CH_W'(1);
                        cbase_next = cbase_reg + CBASE_INC;
                        x_next     = SIG_W'(samp_reg) <<< 17;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            stage_reg     <= '0;
            ch_reg        <= '0;
            row_reg       <= '0;
            cbase_reg     <= '0;
            clr_reg       <= '0;
            active_reg    <= ACTIVE_RESET;
            n_act_reg     <= ACT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            stage_reg     <= stage_next;
            ch_reg        <= ch_next;
            row_reg       <= row_next;
            cbase_reg     <= cbase_next;
            clr_reg       <= clr_next;
            active_reg    <= active_next;
            n_act_reg     <= n_act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg     <= samp_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        s0n_reg      <= s0n_next;
        acc_reg      <= acc_next;
        prod_reg     <= PROD_W'(coef_rd_reg) * PROD_W'(mul_b);
        chan_out_reg <= chan_out_next;
        filt_reg     <= filt_next;
        last_reg     <= last_next;
    end

    // coefficient store
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coeff_value;
        end
        if (coef_re)
        begin
            coef_rd_reg <= coef_mem[coef_raddr];
        end
    end

    // stage state store, one row of s0 and s1 per channel and stage
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            st_rd_reg <= st_mem[row_reg];
        end
    end

    // the marked word is the one for the last active channel
    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_channel) |-> ({1'b0, channel_out} == n_act_reg - ACT_W'(1)))
        else $error("last_channel on wrong channel");

    // sequencer never runs past the end of a stage
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_LAST))
        else $error("step counter out of range");

    // channel counter stays inside the active range while working
    a_channel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN || state_reg == ST_EMIT) |-> ({1'b0, ch_reg} < n_act_reg))
        else $error("channel counter out of range");

    // a new output word only ever comes from the emit step
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_EMIT))
        else $error("output word without emit");

endmodule

[sim/gammatone_biquad_cascade_bank_checker.sv]
// ----------------------------------------------------------------------------
// gammatone_biquad_cascade_bank_checker
// Watches the configuration port and both word channels of the filterbank,
// keeps its own copy of the coefficient table, the biquad state and the
// active channel count, works out the filtered words that every accepted
// sample must give and compares each word that leaves the block with the
// oldest one still waiting.
// ----------------------------------------------------------------------------
module gammatone_biquad_cascade_bank_checker
    import gtbank_pkg::*;
#(
    parameter int NUM_CHANNELS = 64,
    parameter int NUM_STAGES   = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,

    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       command,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [CH_W-1:0]            coeff_channel,
    input  logic [SEL_W-1:0]           coeff_select,
    input  logic signed [COEF_W-1:0]   coeff_value,

    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [CH_W-1:0]            channel_out,
    input  logic signed [OUT_W-1:0]    filtered_sample,
    input  logic                       last_channel,

    output int                         failures,
    output int                         pending
);

    localparam int         NUM_SELECTS = SEL_B0 + 3 * NUM_STAGES;
    localparam logic [2:0] ACTIVE_ADDR = 3'(4 * REG_ACTIVE_CHANNELS);
    localparam longint     SIG_MAX     = 64'sd549755813887;
    localparam longint     SIG_MIN     = -64'sd549755813888;
    localparam longint     OUT_MAX     = 64'sd8388607;
    localparam longint     OUT_MIN     = -64'sd8388608;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [OUT_W-1:0] value;
        logic             last;
    } band_word_t;

    band_word_t               expected_bands[$];
    band_word_t               want;
    logic signed [COEF_W-1:0] coeff_table [NUM_CHANNELS][NUM_SELECTS];
    longint                   biquad_state [NUM_CHANNELS][NUM_STAGES][2];
    logic [ACT_W-1:0]         active_count;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        failures++;
    endtask

    function automatic longint clip40(input longint v);
        if (v > SIG_MAX)
            return SIG_MAX;
        if (v < SIG_MIN)
            return SIG_MIN;
        return v;
    endfunction

    // q4.28 coefficient times q8.32 signal, rounded half up
    function automatic longint scale_product(input logic signed [COEF_W-1:0] c,
                                             input longint x);
        logic signed [71:0] cw;
        logic signed [71:0] xw;
        logic signed [71:0] p;
        cw = 72'(c);
        xw = 72'(x);
        p = (cw * xw + 72'sd134217728) >>> 28;
        return p[63:0];
    endfunction

    function automatic void filter_sample(input logic signed [SAMPLE_W-1:0] s);
        int         bands;
        longint     x;
        longint     y;
        longint     r;
        band_word_t w;
        bands = int'(active_count);
        if (bands < 1)
            bands = 1;
        if (bands > NUM_CHANNELS)
            bands = NUM_CHANNELS;
        for (int c = 0; c < bands; c++)
        begin
            x = longint'(s) * 131072;
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                y = clip40(scale_product(coeff_table[c][SEL_B0 + 3 * k], x)
                    + biquad_state[c][k][0]);
                biquad_state[c][k][0] =
                    clip40(scale_product(coeff_table[c][SEL_B0 + 3 * k + 1], x)
                    - scale_product(coeff_table[c][SEL_A1], y) + biquad_state[c][k][1]);
                biquad_state[c][k][1] =
                    clip40(scale_product(coeff_table[c][SEL_B0 + 3 * k + 2], x)
                    - scale_product(coeff_table[c][SEL_A2], y));
                x = y;
            end
            r = (x + 256) >>> 9;
            if (r > OUT_MAX)
                r = OUT_MAX;
            if (r < OUT_MIN)
                r = OUT_MIN;
            w.channel = CH_W'(c);
            w.value   = r[OUT_W-1:0];
            w.last    = (c == bands - 1);
            expected_bands.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bands.delete();
            active_count = ACTIVE_RESET;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                for (int s = 0; s < NUM_SELECTS; s++)
                    coeff_table[c][s] = '0;
                for (int k = 0; k < NUM_STAGES; k++)
                begin
                    biquad_state[c][k][0] = 0;
                    biquad_state[c][k][1] = 0;
                end
            end
            failures = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bands.size() == 0)
                begin
                    report_mismatch($sformatf("word for channel %0d with none pending",
                        channel_out));
                end
                else
                begin
                    want = expected_bands.pop_front();
                    if (channel_out !== want.channel)
                        report_mismatch($sformatf("channel_out got %0d want %0d",
                            channel_out, want.channel));
                    if (filtered_sample !== want.value)
                        report_mismatch($sformatf("channel %0d filtered_sample got %0d want %0d",
                            want.channel, filtered_sample, $signed(want.value)));
                    if (last_channel !== want.last)
                        report_mismatch($sformatf("channel %0d last_channel got %0b want %0b",
                            want.channel, last_channel, want.last));
                end
            end
            if (psel && penable && pwrite && pready && paddr == ACTIVE_ADDR)
                active_count = pwdata[ACT_W-1:0];
            if (in_valid && !in_stall)
            begin
                if (command == CMD_WRITE)
                begin
                    // selects past the last stage are dropped
                    if (coeff_select < NUM_SELECTS)
                        coeff_table[coeff_channel][coeff_select] = coeff_value;
                end
                else
                begin
                    filter_sample(sample_in);
                end
            end
            pending <= expected_bands.size();
        end
    end

endmodule

[sim/gammatone_biquad_cascade_bank_tb.sv]
// ----------------------------------------------------------------------------
// gammatone_biquad_cascade_bank_tb
// Loads the whole coefficient table, filters corner samples with every
// channel active, then steps through a range of active channel counts with
// random samples and coefficient rewrites while both sides idle at random.
// The checker beside the block predicts and compares every filtered word.
// ----------------------------------------------------------------------------
module gammatone_biquad_cascade_bank_tb;
    import gtbank_pkg::*;

    localparam int         NUM_CHANNELS = 64;
    localparam int         NUM_STAGES   = 4;
    localparam int         NUM_SELECTS  = SEL_B0 + 3 * NUM_STAGES;
    localparam int         NUM_PHASES   = 11;
    localparam int         MAX_GAP      = 8;
    localparam int         LONG_HOLD    = 400;
    localparam int         SETTLE       = 60;
    localparam logic [2:0] ACTIVE_ADDR  = 3'(4 * REG_ACTIVE_CHANNELS);
    localparam logic [2:0] SPARE_ADDR   = 3'd4;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_stall;
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CH_W-1:0]            coeff_channel;
    logic [SEL_W-1:0]           coeff_select;
    logic signed [COEF_W-1:0]   coeff_value;
    logic                       out_valid;
    logic                       out_stall;
    logic [CH_W-1:0]            channel_out;
    logic signed [OUT_W-1:0]    filtered_sample;
    logic                       last_channel;

    int failures;
    int pending;
    bit tx_gaps       = 1'b1;
    bit rx_gaps       = 1'b1;
    bit long_hold_req = 1'b0;

    int plan_active [NUM_PHASES] = '{0, 1, 2, 5, 16, 127, 3, 64, 8, 100, 4};
    int plan_items  [NUM_PHASES] = '{60, 50, 50, 60, 25, 6, 50, 6, 60, 5, 50};
    bit plan_hold   [NUM_PHASES] = '{0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0};

    logic signed [SAMPLE_W-1:0] corner_samples [9] = '{16'sh0000, 16'sh7FFF, 16'sh7FFF,
        16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0001, 16'shFFFF, 16'sh0000};

    gammatone_biquad_cascade_bank #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_STAGES   (NUM_STAGES)
    ) dut (.*);

    gammatone_biquad_cascade_bank_checker #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_STAGES   (NUM_STAGES)
    ) band_check (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #500_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic signed [31:0] signed_within(input int unsigned mag);
        logic signed [31:0] v;
        v = $urandom_range(0, mag);
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return SAMPLE_W'(signed_within(256));
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // mostly stable pole pairs and modest zeros, now and then a wild value
    function automatic logic signed [COEF_W-1:0] pick_coeff(input int sel);
        case ($urandom_range(0, 63))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return '0;
            default:
            begin
                if (sel == SEL_A1)
                    return signed_within(32'h1600_0000);
                if (sel == SEL_A2)
                    return $urandom_range(32'h0800_0000, 32'h0F00_0000);
                return signed_within(32'h0400_0000);
            end
        endcase
    endfunction

    task automatic offer_word(input logic cmd, input logic signed [SAMPLE_W-1:0] s,
                              input logic [CH_W-1:0] ch, input logic [SEL_W-1:0] sel,
                              input logic signed [COEF_W-1:0] v);
        int gap;
        if ($urandom_range(0, 24) == 0)
            tx_gaps = !tx_gaps;
        gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        sample_in     <= s;
        coeff_channel <= ch;
        coeff_select  <= sel;
        coeff_value   <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic feed_sample(input logic signed [SAMPLE_W-1:0] s);
        offer_word(CMD_FILTER, s, CH_W'($urandom_range(0, 63)), SEL_W'($urandom_range(0, 15)),
            $urandom);
    endtask

    task automatic load_coeff(input logic [CH_W-1:0] ch, input logic [SEL_W-1:0] sel,
                              input logic signed [COEF_W-1:0] v);
        offer_word(CMD_WRITE, SAMPLE_W'($urandom_range(0, 65535)), ch, sel, v);
    endtask

    task automatic settle(input int tail);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin : result_sink
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else if (out_valid && !out_stall)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_gaps = !rx_gaps;
                hold = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            out_stall <= (hold > 0);
        end
    end

    initial
    begin : stimulus
        int n;
        int roll;
        int sel;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        command       <= CMD_FILTER;
        sample_in     <= '0;
        coeff_channel <= '0;
        coeff_select  <= '0;
        coeff_value   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // every channel is active out of reset, so the whole table goes in first
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            for (int s = 0; s < NUM_SELECTS; s++)
            begin
                if (ch == NUM_CHANNELS - 1)
                    load_coeff(CH_W'(ch), SEL_W'(s), 32'h7FFF_FFFF);
                else if (ch == NUM_CHANNELS - 2)
                    load_coeff(CH_W'(ch), SEL_W'(s), 32'h8000_0000);
                else if (ch == NUM_CHANNELS - 3)
                    load_coeff(CH_W'(ch), SEL_W'(s), $urandom);
                else
                    load_coeff(CH_W'(ch), SEL_W'(s), pick_coeff(s));
            end
        end
        load_coeff(CH_W'(0), SEL_W'(NUM_SELECTS), $urandom);
        load_coeff(CH_W'(9), SEL_W'(NUM_SELECTS + 1), $urandom);
        foreach (corner_samples[i])
            feed_sample(corner_samples[i]);

        // a register that does not exist leaves the channel count alone
        settle(SETTLE);
        write_reg(SPARE_ADDR, 32'd2);
        feed_sample(rand_sample());

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle(SETTLE);
            write_reg(ACTIVE_ADDR, plan_active[p]);
            if (plan_hold[p])
                long_hold_req = 1'b1;
            n = 0;
            while (n < plan_items[p])
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                begin
                    load_coeff(CH_W'($urandom_range(0, 63)),
                        SEL_W'(NUM_SELECTS + $urandom_range(0, 1)), $urandom);
                end
                else
                begin
                    if (roll < 76)
                    begin
                        feed_sample(rand_sample());
                    end
                    else
                    begin
                        sel = $urandom_range(0, NUM_SELECTS - 1);
                        load_coeff(CH_W'($urandom_range(0, 63)), SEL_W'(sel), pick_coeff(sel));
                    end
                    n++;
                    if (n == plan_items[p] / 2)
                        settle(0);
                end
            end
        end

        settle(SETTLE);
        @(negedge clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
hdl/gtbank_pkg.sv
hdl/gammatone_biquad_cascade_bank.sv
sim/gammatone_biquad_cascade_bank_checker.sv
sim/gammatone_biquad_cascade_bank_tb.sv
